FILE: sv/caau_pkg.sv
// caau_pkg: shared types and constants of the cache array access unit
// holds region and status codes, ccr and tag masks, transaction payloads and fsm state
// no dependencies

package caau_pkg;

    // default array sizes
    localparam int ICACHE_LINES_DEF = 256;
    localparam int OCACHE_LINES_DEF = 512;
    localparam int ICACHE_BYTES_DEF = 8192;
    localparam int OCACHE_BYTES_DEF = 16384;

    // stored tag entry: tag 28..10, dirty 1, valid 0
    localparam int TAG_W = 29;

    // region codes
    localparam logic [2:0] RGN_CCR   = 3'd0;
    localparam logic [2:0] RGN_ITAG  = 3'd1;
    localparam logic [2:0] RGN_IDATA = 3'd2;
    localparam logic [2:0] RGN_OTAG  = 3'd3;
    localparam logic [2:0] RGN_ODATA = 3'd4;

    // opcode codes
    localparam logic OP_READ  = 1'b0;
    localparam logic OP_WRITE = 1'b1;

    // status codes
    localparam logic [1:0] STS_OK       = 2'd0;
    localparam logic [1:0] STS_BAD_SIZE = 2'd1;
    localparam logic [1:0] STS_RESERVED = 2'd2;

    // control register bits
    localparam logic [31:0] CCR_WRITABLE = 32'h0000_89AF;
    localparam logic [31:0] CCR_ICI      = 32'h0000_0800;

    // tag masks
    localparam logic [TAG_W-1:0] TAG_FIELD = 29'h1FFF_FC00;
    localparam logic [TAG_W-1:0] ITAG_MASK = 29'h1FFF_FC01;
    localparam logic [TAG_W-1:0] OTAG_MASK = 29'h1FFF_FC03;

    // request transaction
    typedef struct packed {
        logic        opcode;
        logic [2:0]  region;
        logic [23:0] offset;
        logic        is_longword;
        logic [31:0] write_data;
    } caau_req_t;

    // response transaction
    typedef struct packed {
        logic [31:0] read_data;
        logic [1:0]  status;
        logic [31:0] invalidation_total;
    } caau_rsp_t;

    // tag write-back decision
    typedef struct packed {
        logic             we;
        logic [TAG_W-1:0] data;
    } caau_tag_upd_t;

    // sequencer states
    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_EXEC,
        ST_SWEEP,
        ST_SWEEP_LAST
    } caau_state_t;

endpackage

FILE: sv/caau_if.sv
// caau_req_if, caau_rsp_if: valid/ready channels of the cache array access unit
// a transaction moves when valid and ready are both high at a rising clock edge
// depends on caau_pkg

interface caau_req_if;
    logic                 valid;
    logic                 ready;
    caau_pkg::caau_req_t  data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface caau_rsp_if;
    logic                 valid;
    logic                 ready;
    caau_pkg::caau_rsp_t  data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

FILE: sv/caau_ram.sv
// caau_ram: generic single-clock ram, one write port and one registered read port
// no dependencies

module caau_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
    end

    // registered read port, holds when not enabled
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

FILE: sv/caau_tag_update.sv
// caau_tag_update: new value of a tag entry on a plain or associative write
// depends on caau_pkg

module caau_tag_update (
    input  logic [caau_pkg::TAG_W-1:0] cur,
    input  logic [31:0]                val,
    input  logic                       assoc,
    input  logic [caau_pkg::TAG_W-1:0] mask,
    output caau_pkg::caau_tag_upd_t    upd
);

    logic [caau_pkg::TAG_W-1:0] val_masked;
    logic                       hit;

    assign val_masked = val[caau_pkg::TAG_W-1:0] & mask;

    // associative hit: entry valid and tag field equal
    assign hit = cur[0] &&
        ((cur & caau_pkg::TAG_FIELD) == (val[caau_pkg::TAG_W-1:0] & caau_pkg::TAG_FIELD));

    // plain write stores the masked value, associative write only touches dirty/valid
    always_comb
    begin
        if (!assoc)
        begin
            upd.we   = 1'b1;
            upd.data = val_masked;
        end
        else
        begin
            upd.we   = hit;
            upd.data = (cur & caau_pkg::TAG_FIELD) |
                       {{(caau_pkg::TAG_W-2){1'b0}}, val_masked[1:0]};
        end
    end

endmodule

FILE: sv/cache_array_access_unit.sv
// cache_array_access_unit: top level, cache control register and memory-mapped cache arrays
// depends on caau_pkg, caau_if, caau_ram, caau_tag_update

// Each bus access on req gives one response on rsp. In the idle state the item is
// registered and the tag and data memories are read; in the execute state the result
// is formed and any modified entry is written back, through the single write port of
// each memory. The execute state waits while a previous response is still held on rsp.
// A control register write that sets the instruction-invalidate bit is answered at once,
// then input is held while every instruction tag is read and written back with its
// valid bit cleared. After reset a clearing pass writes zero into all four arrays, one
// entry per cycle in parallel, until every entry of the deepest array (4096 with the
// default sizes) is written; no access is accepted until it ends.

module cache_array_access_unit #(
    parameter int ICACHE_LINES = caau_pkg::ICACHE_LINES_DEF,
    parameter int OCACHE_LINES = caau_pkg::OCACHE_LINES_DEF,
    parameter int ICACHE_BYTES = caau_pkg::ICACHE_BYTES_DEF,
    parameter int OCACHE_BYTES = caau_pkg::OCACHE_BYTES_DEF
) (
    input  logic         clk,
    input  logic         rst_n,
    caau_req_if.sink     req,
    caau_rsp_if.source   rsp
);

    localparam int TW     = caau_pkg::TAG_W;
    localparam int IWORDS = ICACHE_BYTES / 4;
    localparam int OWORDS = OCACHE_BYTES / 4;
    localparam int ITAW   = $clog2(ICACHE_LINES);
    localparam int OTAW   = $clog2(OCACHE_LINES);
    localparam int IWAW   = $clog2(IWORDS);
    localparam int OWAW   = $clog2(OWORDS);
    localparam int MAX_T  = (ICACHE_LINES > OCACHE_LINES) ? ICACHE_LINES : OCACHE_LINES;
    localparam int MAX_W  = (IWORDS > OWORDS) ? IWORDS : OWORDS;
    localparam int CLR_DEPTH = (MAX_T > MAX_W) ? MAX_T : MAX_W;
    localparam int CNTW   = $clog2(CLR_DEPTH + 1);

    caau_pkg::caau_state_t state_reg, state_next;
    logic [CNTW-1:0]       clr_cnt_reg, clr_cnt_next;
    logic [ITAW-1:0]       sw_cnt_reg, sw_cnt_next;
    logic [ITAW-1:0]       sw_waddr_reg, sw_waddr_next;
    logic                  sw_wr_reg, sw_wr_next;
    caau_pkg::caau_req_t   item_reg, item_next;
    logic [31:0]           ccr_reg, ccr_next;
    logic [31:0]           cnt_reg, cnt_next;
    logic                  out_valid_reg, out_valid_next;
    caau_pkg::caau_rsp_t   out_reg, out_next;

    // memory ports
    logic            itag_we, itag_re;
    logic [ITAW-1:0] itag_waddr, itag_raddr;
    logic [TW-1:0]   itag_wdata, itag_rdata;
    logic            otag_we, otag_re;
    logic [OTAW-1:0] otag_waddr, otag_raddr;
    logic [TW-1:0]   otag_wdata, otag_rdata;
    logic            iword_we, iword_re;
    logic [IWAW-1:0] iword_waddr, iword_raddr;
    logic [31:0]     iword_wdata, iword_rdata;
    logic            oword_we, oword_re;
    logic [OWAW-1:0] oword_waddr, oword_raddr;
    logic [31:0]     oword_wdata, oword_rdata;

    // index decode
    logic [23:0]     off_sel;
    logic [ITAW-1:0] itag_idx;
    logic [OTAW-1:0] otag_idx;
    logic [21:0]     iword_full, oword_full;
    logic            iword_ok, oword_ok;
    logic            bad_access;
    logic            out_free;
    caau_pkg::caau_tag_upd_t itag_upd, otag_upd;

    caau_ram #(.WIDTH(TW), .DEPTH(ICACHE_LINES)) u_itag_ram (
        .clk(clk), .we(itag_we), .waddr(itag_waddr), .wdata(itag_wdata),
        .re(itag_re), .raddr(itag_raddr), .rdata(itag_rdata)
    );

    caau_ram #(.WIDTH(TW), .DEPTH(OCACHE_LINES)) u_otag_ram (
        .clk(clk), .we(otag_we), .waddr(otag_waddr), .wdata(otag_wdata),
        .re(otag_re), .raddr(otag_raddr), .rdata(otag_rdata)
    );

    caau_ram #(.WIDTH(32), .DEPTH(IWORDS)) u_iword_ram (
        .clk(clk), .we(iword_we), .waddr(iword_waddr), .wdata(iword_wdata),
        .re(iword_re), .raddr(iword_raddr), .rdata(iword_rdata)
    );

    caau_ram #(.WIDTH(32), .DEPTH(OWORDS)) u_oword_ram (
        .clk(clk), .we(oword_we), .waddr(oword_waddr), .wdata(oword_wdata),
        .re(oword_re), .raddr(oword_raddr), .rdata(oword_rdata)
    );

    // tag modify logic for both address arrays
    caau_tag_update u_itag_update (
        .cur(itag_rdata), .val(item_reg.write_data), .assoc(item_reg.offset[3]),
        .mask(caau_pkg::ITAG_MASK), .upd(itag_upd)
    );

    caau_tag_update u_otag_update (
        .cur(otag_rdata), .val(item_reg.write_data), .assoc(item_reg.offset[3]),
        .mask(caau_pkg::OTAG_MASK), .upd(otag_upd)
    );

    // offset of the incoming transaction while idle, of the held item otherwise
    assign off_sel  = (state_reg == caau_pkg::ST_IDLE) ? req.data.offset : item_reg.offset;
    assign itag_idx = ITAW'(off_sel[23:5] & 19'(ICACHE_LINES - 1));
    assign otag_idx = OTAW'(off_sel[23:5] & 19'(OCACHE_LINES - 1));
    assign iword_full = 22'((off_sel & 24'(ICACHE_BYTES - 1)) >> 2);
    assign oword_full = 22'((off_sel & 24'(OCACHE_BYTES - 1)) >> 2);
    assign iword_ok = iword_full < 22'(IWORDS);
    assign oword_ok = oword_full < 22'(OWORDS);

    // width, alignment, region and control register offset checks on the held item
    assign bad_access = !item_reg.is_longword || (item_reg.offset[1:0] != 2'b00) ||
                        (item_reg.region > caau_pkg::RGN_ODATA) ||
                        ((item_reg.region == caau_pkg::RGN_CCR) && (item_reg.offset != 24'd0));

    assign out_free  = !out_valid_reg || rsp.ready;
    assign req.ready = (state_reg == caau_pkg::ST_IDLE);
    assign rsp.valid = out_valid_reg;
    assign rsp.data  = out_reg;

    // state and control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= caau_pkg::ST_CLEAR;
            clr_cnt_reg   <= '0;
            sw_cnt_reg    <= '0;
            sw_waddr_reg  <= '0;
            sw_wr_reg     <= 1'b0;
            ccr_reg       <= '0;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            clr_cnt_reg   <= clr_cnt_next;
            sw_cnt_reg    <= sw_cnt_next;
            sw_waddr_reg  <= sw_waddr_next;
            sw_wr_reg     <= sw_wr_next;
            ccr_reg       <= ccr_next;
            cnt_reg       <= cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        item_reg <= item_next;
        out_reg  <= out_next;
    end

    // sequencer: next state, memory controls and response
    always_comb
    begin
        state_next     = state_reg;
        clr_cnt_next   = clr_cnt_reg;
        sw_cnt_next    = sw_cnt_reg;
        sw_waddr_next  = sw_waddr_reg;
        sw_wr_next     = sw_wr_reg;
        item_next      = item_reg;
        ccr_next       = ccr_reg;
        cnt_next       = cnt_reg;
        out_valid_next = out_valid_reg && !rsp.ready;
        out_next       = out_reg;

        itag_we = 1'b0; itag_waddr = itag_idx; itag_wdata = itag_upd.data;
        itag_re = 1'b0; itag_raddr = itag_idx;
        otag_we = 1'b0; otag_waddr = otag_idx; otag_wdata = otag_upd.data;
        otag_re = 1'b0; otag_raddr = otag_idx;
        iword_we = 1'b0; iword_waddr = iword_full[IWAW-1:0];
        iword_wdata = item_reg.write_data;
        iword_re = 1'b0; iword_raddr = iword_full[IWAW-1:0];
        oword_we = 1'b0; oword_waddr = oword_full[OWAW-1:0];
        oword_wdata = item_reg.write_data;
        oword_re = 1'b0; oword_raddr = oword_full[OWAW-1:0];

        case (state_reg)
            // zero every array, one entry per cycle
            caau_pkg::ST_CLEAR:
            begin
                itag_we     = clr_cnt_reg < CNTW'(ICACHE_LINES);
                itag_waddr  = clr_cnt_reg[ITAW-1:0];
                itag_wdata  = '0;
                otag_we     = clr_cnt_reg < CNTW'(OCACHE_LINES);
                otag_waddr  = clr_cnt_reg[OTAW-1:0];
                otag_wdata  = '0;
                iword_we    = clr_cnt_reg < CNTW'(IWORDS);
                iword_waddr = clr_cnt_reg[IWAW-1:0];
                iword_wdata = '0;
                oword_we    = clr_cnt_reg < CNTW'(OWORDS);
                oword_waddr = clr_cnt_reg[OWAW-1:0];
                oword_wdata = '0;
                clr_cnt_next = clr_cnt_reg + CNTW'(1);
                if (clr_cnt_reg == CNTW'(CLR_DEPTH - 1))
                begin
                    state_next = caau_pkg::ST_IDLE;
                end
            end

            // accept a transaction and start the array reads
            caau_pkg::ST_IDLE:
            begin
                if (req.valid)
                begin
                    item_next  = req.data;
                    itag_re    = 1'b1;
                    otag_re    = 1'b1;
                    iword_re   = 1'b1;
                    oword_re   = 1'b1;
                    state_next = caau_pkg::ST_EXEC;
                end
            end

            // form the response and write back once the output slot is free
            caau_pkg::ST_EXEC:
            begin
                if (out_free)
                begin
                    out_next.read_data          = '0;
                    out_next.status             = caau_pkg::STS_OK;
                    out_next.invalidation_total = cnt_reg;
                    state_next                  = caau_pkg::ST_IDLE;
                    if (bad_access)
                    begin
                        out_next.status = caau_pkg::STS_BAD_SIZE;
                    end
                    else
                    begin
                        case (item_reg.region)
                            caau_pkg::RGN_CCR:
                            begin
                                if (item_reg.opcode == caau_pkg::OP_READ)
                                begin
                                    out_next.read_data = ccr_reg;
                                end
                                else if ((item_reg.write_data & ~caau_pkg::CCR_WRITABLE)
                                         != 32'd0)
                                begin
                                    out_next.status = caau_pkg::STS_RESERVED;
                                end
                                else
                                begin
                                    ccr_next = item_reg.write_data & caau_pkg::CCR_WRITABLE &
                                               ~caau_pkg::CCR_ICI;
                                    if ((item_reg.write_data & caau_pkg::CCR_ICI) != 32'd0)
                                    begin
                                        cnt_next = cnt_reg + 32'd1;
                                        out_next.invalidation_total = cnt_reg + 32'd1;
                                        sw_cnt_next = '0;
                                        sw_wr_next  = 1'b0;
                                        state_next  = caau_pkg::ST_SWEEP;
                                    end
                                end
                            end
                            caau_pkg::RGN_ITAG:
                            begin
                                if (item_reg.opcode == caau_pkg::OP_WRITE)
                                begin
                                    itag_we = itag_upd.we;
                                end
                                else
                                begin
                                    out_next.read_data = {{(32-TW){1'b0}}, itag_rdata};
                                end
                            end
                            caau_pkg::RGN_OTAG:
                            begin
                                if (item_reg.opcode == caau_pkg::OP_WRITE)
                                begin
                                    otag_we = otag_upd.we;
                                end
                                else
                                begin
                                    out_next.read_data = {{(32-TW){1'b0}}, otag_rdata};
                                end
                            end
                            caau_pkg::RGN_IDATA:
                            begin
                                if (item_reg.opcode == caau_pkg::OP_WRITE)
                                begin
                                    iword_we = iword_ok;
                                end
                                else if (iword_ok)
                                begin
                                    out_next.read_data = iword_rdata;
                                end
                            end
                            caau_pkg::RGN_ODATA:
                            begin
                                if (item_reg.opcode == caau_pkg::OP_WRITE)
                                begin
                                    oword_we = oword_ok;
                                end
                                else if (oword_ok)
                                begin
                                    out_next.read_data = oword_rdata;
                                end
                            end
                            default:
                            begin
                                out_next.status = caau_pkg::STS_BAD_SIZE;
                            end
                        endcase
                    end
                    out_valid_next = 1'b1;
                end
            end

            // invalidate walk: read tag n while writing back tag n-1
            caau_pkg::ST_SWEEP:
            begin
                itag_re       = 1'b1;
                itag_raddr    = sw_cnt_reg;
                itag_we       = sw_wr_reg;
                itag_waddr    = sw_waddr_reg;
                itag_wdata    = {itag_rdata[TW-1:1], 1'b0};
                sw_waddr_next = sw_cnt_reg;
                sw_wr_next    = 1'b1;
                sw_cnt_next   = sw_cnt_reg + ITAW'(1);
                if (sw_cnt_reg == ITAW'(ICACHE_LINES - 1))
                begin
                    state_next = caau_pkg::ST_SWEEP_LAST;
                end
            end

            // write back the last tag of the walk
            caau_pkg::ST_SWEEP_LAST:
            begin
                itag_we    = 1'b1;
                itag_waddr = sw_waddr_reg;
                itag_wdata = {itag_rdata[TW-1:1], 1'b0};
                sw_wr_next = 1'b0;
                state_next = caau_pkg::ST_IDLE;
            end

            default:
            begin
                state_next = caau_pkg::ST_IDLE;
            end
        endcase
    end

endmodule
